### rtl/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared widths, fixed-point constants and sector codes for the HSV to RGB
// pixel pipeline.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int HUE_W = 15;
  localparam int CH_W = 8;
  localparam int RGB_W = 3 * CH_W;
  localparam int HUE_FRAC_BITS = 6;

  // one 60 degree sector in hue units, and the 120 degree fold period
  localparam int SPAN = 60 << HUE_FRAC_BITS;
  localparam int HQ_D = 2 * SPAN;
  localparam int HUE_MAX = (1 << HUE_W) - 1;
  localparam int WRAP_MAX = HUE_MAX / HQ_D;
  localparam int WRAP_W = (WRAP_MAX > 0) ? $clog2(WRAP_MAX + 1) : 1;
  localparam int SPAN_W = $clog2(HQ_D + 1);
  localparam int WIDE_W = (SPAN_W > HUE_W) ? SPAN_W : HUE_W;

  // hue / HQ_D by reciprocal
  localparam int HQ_K = HUE_W + $clog2(HQ_D);
  localparam longint HQ_M = ((longint'(1) << HQ_K) + longint'(HQ_D) - 1) / longint'(HQ_D);
  localparam int HQ_M_W = $clog2(HQ_M + 1);
  localparam int HQ_P_W = HUE_W + HQ_M_W;

  // folded hue position, mixing term and product widths
  localparam int Q_W = $clog2(SPAN + 1);
  localparam int T_W = $clog2(255 * longint'(SPAN) + 1);
  localparam int N_W = T_W + CH_W;
  localparam int VNS_W = 2 * CH_W;

  // low level: (v * (255 - s)) / 255 by reciprocal
  localparam int LOW_D = 255;
  localparam int LOW_K = VNS_W + $clog2(LOW_D);
  localparam longint LOW_M = ((longint'(1) << LOW_K) + LOW_D - 1) / LOW_D;
  localparam int LOW_M_W = $clog2(LOW_M + 1);
  localparam int LOW_P_W = VNS_W + LOW_M_W;

  // mid level: ((v * t) >> frac) / (255 * 60) by reciprocal
  localparam int MID_D = 255 * 60;
  localparam int X_W = $clog2(65025 * 60 + 1);
  localparam int MID_K = X_W + $clog2(MID_D);
  localparam longint MID_M = ((longint'(1) << MID_K) + MID_D - 1) / MID_D;
  localparam int MID_M_W = $clog2(MID_M + 1);
  localparam int MID_P_W = X_W + MID_M_W;

  typedef enum logic [2:0] {
    SEC_R_Y = 3'd0,
    SEC_Y_G = 3'd1,
    SEC_G_C = 3'd2,
    SEC_C_B = 3'd3,
    SEC_B_M = 3'd4,
    SEC_M_R = 3'd5
  } sector_t;

endpackage

### rtl/hsv_to_rgb_pixel_unit.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel_unit
// Six-stage pipelined HSV to RGB conversion, one pixel per clock unless stalled.
// ----------------------------------------------------------------------------
//
//   channel | handshake          | payload
//   --------+--------------------+-------------------------------------------
//   in      | in_valid, in_stall | hue, saturation, brightness
//   out     | out_valid,out_stall| red, green, blue, packed_rgb
//
// one item enters and one leaves every clock while out_stall is low
// the longest stage is one 22 x 23 reciprocal multiply for the mid level
// rst clears the stage valid bits only, payload registers are not reset
// a stall fills empty stages first, in_stall rises only when all six are full
//
module hsv_to_rgb_pixel_unit
  import hsv2rgb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [HUE_W-1:0]  hue,
  input  logic [CH_W-1:0]   saturation,
  input  logic [CH_W-1:0]   brightness,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CH_W-1:0]   red,
  output logic [CH_W-1:0]   green,
  output logic [CH_W-1:0]   blue,
  output logic [RGB_W-1:0]  packed_rgb
);

  localparam logic [HQ_M_W-1:0]  HQ_MV  = HQ_M_W'(HQ_M);
  localparam logic [LOW_M_W-1:0] LOW_MV = LOW_M_W'(LOW_M);
  localparam logic [MID_M_W-1:0] MID_MV = MID_M_W'(MID_M);

  logic [5:0] stage_valid;
  logic [5:0] adv;

  // stage 1
  logic [HUE_W-1:0]  s1_hue;
  logic [CH_W-1:0]   s1_sat;
  logic [CH_W-1:0]   s1_val;
  logic [WRAP_W-1:0] s1_wrap;
  // stage 2
  logic [HUE_W-1:0]  s2_pos;
  sector_t           s2_sector;
  logic [CH_W-1:0]   s2_sat;
  logic [CH_W-1:0]   s2_val;
  logic [VNS_W-1:0]  s2_vns;
  // stage 3
  logic [Q_W-1:0]    s3_q;
  logic [CH_W-1:0]   s3_low;
  sector_t           s3_sector;
  logic [CH_W-1:0]   s3_sat;
  logic [CH_W-1:0]   s3_val;
  // stage 4
  logic [T_W-1:0]    s4_t;
  logic [CH_W-1:0]   s4_low;
  sector_t           s4_sector;
  logic [CH_W-1:0]   s4_val;
  // stage 5
  logic [X_W-1:0]    s5_x;
  logic [CH_W-1:0]   s5_low;
  sector_t           s5_sector;
  logic [CH_W-1:0]   s5_val;

  logic [HQ_P_W-1:0]  hq_prod;
  logic [HUE_W-1:0]   wrap_base;
  logic [HUE_W-1:0]   pos_next;
  logic               fold2;
  sector_t            sector_next;
  logic [WIDE_W-1:0]  pos_w;
  logic [WIDE_W-1:0]  q_w;
  logic [LOW_P_W-1:0] low_prod;
  logic [T_W-1:0]     t_next;
  logic [N_W-1:0]     n_prod;
  logic [MID_P_W-1:0] mid_prod;
  logic [CH_W-1:0]    mid;

  // pipeline advance, a stage moves when it is empty or the next one moves
  always_comb begin
    adv[5] = !stage_valid[5] || !out_stall;
    for (int i = 4; i >= 0; i--) begin
      adv[i] = !stage_valid[i] || adv[i+1];
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = stage_valid[5];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (adv[0]) begin
        stage_valid[0] <= in_valid;
      end
      for (int i = 1; i < 6; i++) begin
        if (adv[i]) begin
          stage_valid[i] <= stage_valid[i-1];
        end
      end
    end
  end

  // stage 1: number of whole 120 degree periods in hue
  assign hq_prod = HQ_P_W'(hue) * HQ_P_W'(HQ_MV);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_hue  <= hue;
      s1_sat  <= saturation;
      s1_val  <= brightness;
      s1_wrap <= hq_prod[HQ_K +: WRAP_W];
    end
  end

  // stage 2: position inside the period, sector, v * (255 - s)
  assign wrap_base = HUE_W'(s1_wrap * HQ_D);
  assign pos_next  = s1_hue - wrap_base;
  assign fold2     = WIDE_W'(pos_next) >= WIDE_W'(SPAN);

  always_comb begin
    if (s1_wrap > WRAP_W'(2)) begin
      sector_next = SEC_M_R;
    end else begin
      sector_next = sector_t'({2'(s1_wrap), fold2});
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_pos    <= pos_next;
      s2_sector <= sector_next;
      s2_sat    <= s1_sat;
      s2_val    <= s1_val;
      s2_vns    <= VNS_W'(s1_val) * VNS_W'(CH_W'(LOW_D) - s1_sat);
    end
  end

  // stage 3: distance from the nearest primary, low level
  assign pos_w    = WIDE_W'(s2_pos);
  assign q_w      = (pos_w >= WIDE_W'(SPAN)) ? (WIDE_W'(HQ_D) - pos_w) : pos_w;
  assign low_prod = LOW_P_W'(s2_vns) * LOW_P_W'(LOW_MV);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_q      <= Q_W'(q_w);
      s3_low    <= low_prod[LOW_K +: CH_W];
      s3_sector <= s2_sector;
      s3_sat    <= s2_sat;
      s3_val    <= s2_val;
    end
  end

  // stage 4: t = s * q + (255 - s) * span
  assign t_next = T_W'(s3_sat) * T_W'(s3_q) + T_W'(CH_W'(LOW_D) - s3_sat) * T_W'(SPAN);

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s4_t      <= t_next;
      s4_low    <= s3_low;
      s4_sector <= s3_sector;
      s4_val    <= s3_val;
    end
  end

  // stage 5: v * t, fraction bits of hue dropped
  assign n_prod = N_W'(s4_val) * N_W'(s4_t);

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s5_x      <= X_W'(n_prod >> HUE_FRAC_BITS);
      s5_low    <= s4_low;
      s5_sector <= s4_sector;
      s5_val    <= s4_val;
    end
  end

  // stage 6: mid level and channel ordering
  assign mid_prod = MID_P_W'(s5_x) * MID_P_W'(MID_MV);
  assign mid      = mid_prod[MID_K +: CH_W];

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      unique case (s5_sector)
        SEC_R_Y: begin
          red <= s5_val;  green <= mid;    blue <= s5_low;
        end
        SEC_Y_G: begin
          red <= mid;     green <= s5_val; blue <= s5_low;
        end
        SEC_G_C: begin
          red <= s5_low;  green <= s5_val; blue <= mid;
        end
        SEC_C_B: begin
          red <= s5_low;  green <= mid;    blue <= s5_val;
        end
        SEC_B_M: begin
          red <= mid;     green <= s5_low; blue <= s5_val;
        end
        SEC_M_R: begin
          red <= s5_val;  green <= s5_low; blue <= mid;
        end
        default: begin
          red <= s5_val;  green <= s5_low; blue <= mid;
        end
      endcase
    end
  end

  assign packed_rgb = {red, green, blue};

endmodule

### rtl/hsv2rgb_chk.sv
// ----------------------------------------------------------------------------
// hsv2rgb_chk
// Port-level checks for the HSV to RGB pixel pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module hsv2rgb_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  red,
  input logic [7:0]  green,
  input logic [7:0]  blue,
  input logic [23:0] packed_rgb
);

  // a stalled item stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(packed_rgb))
    else $error("stalled output item changed");

  // packed word follows the channels
  a_packed: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> packed_rgb == {red, green, blue})
    else $error("packed_rgb does not match channels");

  // input only backs up when the pipe is full and the output is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with room in the pipe");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipe not empty after reset");

endmodule

bind hsv_to_rgb_pixel_unit hsv2rgb_chk u_hsv2rgb_chk (.*);
